@@ hw/rtl/lpcp_pkg.sv @@
package lpcp_pkg;

    localparam int COEF_W   = 32;
    localparam int CRD_W    = 24;
    localparam int PROD_W   = COEF_W + CRD_W;
    // Three products plus the translation term, worst case below 2^57.
    localparam int ACC_W    = PROD_W + 2;
    localparam int MAG_W    = ACC_W;
    localparam int PIX_W    = 32;
    localparam int PIX_FRAC = 8;
    localparam int INT_BITS = 24;
    // Integer bits, fraction bits and one extra bit for rounding.
    localparam int QB       = INT_BITS + PIX_FRAC + 1;
    localparam int DEPTH_W  = 40;
    localparam int NUM_REGS = 6;
    localparam int IDX_W    = 3;
    localparam int REG_W    = 64;
    localparam int QDEPTH   = 8;
    localparam int QPTR_W   = 3;
    localparam int QCNT_W   = 4;
    // Divider stages: prepare, initialise, one per quotient bit, round.
    localparam int DIV_LAT  = QB + 3;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc_x;
        logic signed [ACC_W-1:0] acc_y;
        logic signed [ACC_W-1:0] acc_z;
        logic                    last;
    } entry_t;

    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic                      zero;
        logic                      last;
    } side_t;

endpackage

@@ hw/rtl/lpcp_front.sv @@
module lpcp_front
    import lpcp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic signed [CRD_W-1:0]            point_x,
    input  logic signed [CRD_W-1:0]            point_y,
    input  logic signed [CRD_W-1:0]            point_z,
    input  logic                               last_in,
    input  logic [NUM_REGS-1:0][REG_W-1:0]     coef,
    output logic                               push,
    output entry_t                             entry,
    output logic [1:0]                         inflight
);

    logic signed [CRD_W-1:0]  pt [3];
    logic signed [COEF_W-1:0] cm [3][4];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [COEF_W-1:0] trans_reg [3];
    logic                     last_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [ACC_W-1:0]  acc_next [3];
    logic signed [ACC_W-1:0]  acc_reg [3];
    logic                     last2_reg;

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                cm[r][c] = $signed(coef[r*2 + c/2][(c%2)*COEF_W +: COEF_W]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[r][c] <= cm[r][c] * pt[c];
            end
            trans_reg[r] <= cm[r][3];
        end
        last_reg <= last_in;
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_next[r] = ACC_W'(prod_reg[r][0]) + ACC_W'(prod_reg[r][1])
                        + ACC_W'(prod_reg[r][2])
                        + (ACC_W'(trans_reg[r]) <<< COORD_FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_reg[r] <= acc_next[r];
        end
        last2_reg <= last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    assign push        = v2_reg;
    assign entry.acc_x = acc_reg[0];
    assign entry.acc_y = acc_reg[1];
    assign entry.acc_z = acc_reg[2];
    assign entry.last  = last2_reg;
    assign inflight    = {1'b0, v1_reg} + {1'b0, v2_reg};

endmodule

@@ hw/rtl/lpcp_queue.sv @@
module lpcp_queue
    import lpcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  entry_t            wr_entry,
    input  logic              pop,
    output entry_t            rd_entry,
    output logic              empty,
    output logic [QCNT_W-1:0] count
);

    entry_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign rd_entry = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(QDEPTH)) |-> (!push || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");

endmodule

@@ hw/rtl/lpcp_div.sv @@
module lpcp_div
    import lpcp_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ACC_W-1:0] num,
    input  logic signed [ACC_W-1:0] den,
    output logic [PIX_W-1:0]        quo
);

    localparam int REM_W = MAG_W + PIX_FRAC + 1;
    localparam int TW    = MAG_W + QB;

    logic [MAG_W-1:0]   n_reg;
    logic [MAG_W-1:0]   d0_reg;
    logic               neg0_reg;
    logic [REM_W-1:0]   rem_reg  [QB+1];
    logic [QB-1:0]      q_reg    [QB+1];
    logic [MAG_W-1:0]   d_reg    [QB+1];
    logic               neg_reg  [QB+1];
    logic               sat_reg  [QB+1];
    logic [QB+1:0]      rnd;
    logic [QB:0]        qmag;
    logic [PIX_W-1:0]   quo_next;
    logic [PIX_W-1:0]   quo_reg;

    // Magnitudes and sign of the quotient.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= num[ACC_W-1] ? MAG_W'(-num) : MAG_W'(num);
            d0_reg   <= den[ACC_W-1] ? MAG_W'(-den) : MAG_W'(den);
            neg0_reg <= num[ACC_W-1] ^ den[ACC_W-1];
        end
    end

    // An integer part of 2^24 or more saturates whatever the fraction.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= REM_W'(n_reg) << (PIX_FRAC + 1);
            q_reg[0]   <= '0;
            d_reg[0]   <= d0_reg;
            neg_reg[0] <= neg0_reg;
            sat_reg[0] <= {{INT_BITS{1'b0}}, n_reg} >= {d0_reg, {INT_BITS{1'b0}}};
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_bit
        localparam int B = QB - k;
        logic [TW-1:0] remx;
        logic [TW-1:0] dsh;
        logic          ge;

        assign remx = TW'(rem_reg[k-1]);
        assign dsh  = TW'(d_reg[k-1]) << B;
        assign ge   = remx >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? REM_W'(remx - dsh) : rem_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (QB'(ge) << B);
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    // Round half away from zero on the extra bit, then clamp to 32 bits.
    always_comb
    begin
        rnd  = {2'b00, q_reg[QB]} + 1'b1;
        qmag = sat_reg[QB] ? ((QB+1)'(1) << (PIX_W-1)) + 1'b1 : rnd[QB+1:1];
        if (neg_reg[QB])
        begin
            if (qmag >= ((QB+1)'(1) << (PIX_W-1)))
            begin
                quo_next = {1'b1, {(PIX_W-1){1'b0}}};
            end
            else
            begin
                quo_next = PIX_W'(-qmag);
            end
        end
        else
        begin
            if (qmag > (QB+1)'({1'b0, {(PIX_W-1){1'b1}}}))
            begin
                quo_next = {1'b0, {(PIX_W-1){1'b1}}};
            end
            else
            begin
                quo_next = PIX_W'(qmag);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

@@ hw/rtl/lpcp_back.sv @@
module lpcp_back
    import lpcp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  entry_t                    rd_entry,
    input  logic                      empty,
    output logic                      pop,
    output logic signed [PIX_W-1:0]   pixel_u,
    output logic signed [PIX_W-1:0]   pixel_v,
    output logic signed [DEPTH_W-1:0] depth,
    output logic                      zero_depth,
    output logic                      last_out,
    output logic                      pixel_valid,
    input  logic                      pixel_stall
);

    logic                    en;
    entry_t                  b0_reg;
    logic                    vld_reg [DIV_LAT+1];
    side_t                   side_reg [DIV_LAT];
    side_t                   side_next;
    logic signed [ACC_W:0]   dsum;
    logic signed [ACC_W:0]   dsh;
    logic [PIX_W-1:0]        quo_u;
    logic [PIX_W-1:0]        quo_v;

    // The whole back pipeline moves while the output register is free or drained.
    assign en  = !vld_reg[DIV_LAT] || !pixel_stall;
    assign pop = en && !empty;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_reg <= rd_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= !empty;
            for (int i = 1; i <= DIV_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Depth rounds half up, then clamps to 40 bits.
    always_comb
    begin
        dsum = (ACC_W+1)'(b0_reg.acc_z) + ((ACC_W+1)'(1) <<< (COEF_FRAC_BITS - 1));
        dsh  = dsum >>> COEF_FRAC_BITS;
        side_next.zero = (b0_reg.acc_z == '0);
        side_next.last = b0_reg.last;
        if (side_next.zero)
        begin
            side_next.depth = '0;
        end
        else if (dsh[ACC_W:DEPTH_W-1] != {(ACC_W-DEPTH_W+2){dsh[ACC_W]}})
        begin
            side_next.depth = {dsh[ACC_W], {(DEPTH_W-1){!dsh[ACC_W]}}};
        end
        else
        begin
            side_next.depth = dsh[DEPTH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    lpcp_div u_div_u (
        .clk (clk),
        .en  (en),
        .num (b0_reg.acc_x),
        .den (b0_reg.acc_z),
        .quo (quo_u)
    );

    lpcp_div u_div_v (
        .clk (clk),
        .en  (en),
        .num (b0_reg.acc_y),
        .den (b0_reg.acc_z),
        .quo (quo_v)
    );

    assign pixel_valid = vld_reg[DIV_LAT];
    assign zero_depth  = side_reg[DIV_LAT-1].zero;
    assign last_out    = side_reg[DIV_LAT-1].last;
    assign depth       = side_reg[DIV_LAT-1].depth;
    assign pixel_u     = zero_depth ? '0 : $signed(quo_u);
    assign pixel_v     = zero_depth ? '0 : $signed(quo_v);

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && zero_depth) |-> (pixel_u == '0 && pixel_v == '0 && depth == '0))
        else $error("zero depth result carries non-zero fields");

endmodule

@@ hw/rtl/lidar_point_camera_projection_unit.sv @@
// A point passes the front multipliers, the queue and the dividers to the output register.
// Throughput: one point per cycle unless stalled; a restoring divider pair sets the depth.
// The front multiplier stages feed an 8-entry queue; point_stall rises when it could fill.
// Reset is asynchronous and active low: coefficients clear to zero, all valids drop.
// The coefficient port is always ready; writes to indices beyond five are dropped.
module lidar_point_camera_projection_unit
    import lpcp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 10,
    parameter int COEF_FRAC_BITS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [REG_W-1:0]          cfg_data,
    input  logic                      point_valid,
    output logic                      point_stall,
    input  logic signed [CRD_W-1:0]   point_x,
    input  logic signed [CRD_W-1:0]   point_y,
    input  logic signed [CRD_W-1:0]   point_z,
    input  logic                      last_in,
    output logic                      pixel_valid,
    input  logic                      pixel_stall,
    output logic signed [PIX_W-1:0]   pixel_u,
    output logic signed [PIX_W-1:0]   pixel_v,
    output logic signed [DEPTH_W-1:0] depth,
    output logic                      zero_depth,
    output logic                      last_out
);

    // The six coefficient registers hold the premultiplied 3x4 projection
    // matrix, two signed coefficients per register, the first in the low half.
    logic [NUM_REGS-1:0][REG_W-1:0] coef_reg;
    logic                           accept;
    logic                           push;
    logic                           pop;
    logic                           empty;
    entry_t                         wr_entry;
    entry_t                         rd_entry;
    logic [QCNT_W-1:0]              count;
    logic [1:0]                     inflight;
    logic [QCNT_W:0]                occupancy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_valid && cfg_ready && (cfg_index < IDX_W'(NUM_REGS)))
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // A point is taken only while the queue has room for it and for every
    // transaction still inside the front multiplier stages, so the front never
    // has to stall on its own and the queue never overflows.
    assign occupancy   = (QCNT_W+1)'(count) + (QCNT_W+1)'(inflight);
    assign point_stall = occupancy >= (QCNT_W+1)'(QDEPTH - 1);
    assign accept      = point_valid && !point_stall;

    lpcp_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .last_in  (last_in),
        .coef     (coef_reg),
        .push     (push),
        .entry    (wr_entry),
        .inflight (inflight)
    );

    lpcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .empty    (empty),
        .count    (count)
    );

    // The back end divides X and Y by Z in two bit-per-stage pipelines and
    // rounds the depth alongside; it holds still only while the output
    // transaction is stalled.
    lpcp_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_entry    (rd_entry),
        .empty       (empty),
        .pop         (pop),
        .pixel_u     (pixel_u),
        .pixel_v     (pixel_v),
        .depth       (depth),
        .zero_depth  (zero_depth),
        .last_out    (last_out),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall)
    );

endmodule
